// File: rtl/playback_priority_ring_scheduler_core_assert.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef PLAYBACK_PRIORITY_RING_SCHEDULER_CORE_ASSERT_SVH
`define PLAYBACK_PRIORITY_RING_SCHEDULER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PPRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PPRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pprs_pkg.sv
// Package with the types and codes of the playback priority ring scheduler.
`default_nettype none

package pprs_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_BUFFERED   = 3'd0;
    localparam logic [2:0] ST_REJ_LOWER  = 3'd1;
    localparam logic [2:0] ST_REJ_FULL   = 3'd2;
    localparam logic [2:0] ST_DISPATCHED = 3'd3;
    localparam logic [2:0] ST_NOT_DUE    = 3'd4;
    localparam logic [2:0] ST_HELD_AUDIO = 3'd5;
    localparam logic [2:0] ST_CLEARED    = 3'd6;

    localparam logic [9:0] LEAD_RESET = 10'd15;

    // Queued item without its tag, whose width is set by the top level.
    typedef struct packed {
        logic [7:0]  level;
        logic [15:0] chunk;
        logic        audio;
    } entry_t;

    // Per-cell control: move one place towards the head, or load new data.
    typedef struct packed {
        logic shift;
        logic ins;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/pprs_cell.sv
// One queue cell: holds an item and either shifts from its neighbour or loads.
`default_nettype none

module pprs_cell #(
    parameter int TAG_BITS = 16
) (
    input  wire logic                 clk,
    input  wire pprs_pkg::cell_ctrl_t ctrl,
    input  wire pprs_pkg::entry_t     right_entry,
    input  wire logic [TAG_BITS-1:0]  right_tag,
    input  wire pprs_pkg::entry_t     ins_entry,
    input  wire logic [TAG_BITS-1:0]  ins_tag,
    output pprs_pkg::entry_t          entry,
    output logic [TAG_BITS-1:0]       tag
);

    pprs_pkg::entry_t          entry_reg;
    logic [TAG_BITS-1:0]       tag_reg;

    // A load takes priority over the shift from the neighbouring cell.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            entry_reg <= ins_entry;
            tag_reg   <= ins_tag;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= right_entry;
            tag_reg   <= right_tag;
        end
    end

    assign entry = entry_reg;
    assign tag   = tag_reg;

endmodule

`default_nettype wire

// File: rtl/playback_priority_ring_scheduler_core.sv
// Top level of the playback priority ring scheduler.
// Usage: a transaction on the input channel (in_valid, in_stall) carries one
// command: push an item, tick with the current time, or clear the queue.
// Every command yields exactly one result transaction on the output channel
// (out_valid, out_stall), which reports the status, the items dropped, an
// eviction, the dispatched item and the depth of the queue afterwards.
// The queue is a row of CAPACITY cells with the oldest item in the first cell;
// a dispatch or an eviction moves every cell one place towards the head.
// Sequence: a tick, a clear or a push without replacement goes from the latched
// command through the execute state to the result register. A replacing push
// first walks the queued items, one per cycle, in the compaction state.
// One command is in flight at a time; the next is taken once the result has
// been passed on.
// A stalled result is held unchanged until it is taken, and no new command is
// accepted meanwhile. Reset empties the queue, forgets the last dispatch and
// sets the dispatch lead register, at byte address 0 of the APB port, to 15.
`default_nettype none

module playback_priority_ring_scheduler_core #(
    parameter int CAPACITY = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  item_level,
    input  wire logic        replace_flag,
    input  wire logic [15:0] item_chunk_ms,
    input  wire logic        item_has_audio,
    input  wire logic [15:0] item_tag,
    input  wire logic [31:0] now_ms,
    input  wire logic        speaker_full,
    // Result channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [5:0]       dropped_count,
    output logic             evicted_oldest,
    output logic [15:0]      out_tag,
    output logic [7:0]       out_level,
    output logic [15:0]      out_chunk_ms,
    output logic [5:0]       ring_depth,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPACT,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [7:0]          newest_level_reg;
    logic [31:0]         last_time_reg;
    logic [15:0]         last_chunk_reg;
    logic                once_reg;
    logic [9:0]          lead_reg;

    // Latched command.
    logic [1:0]          op_reg;
    logic [7:0]          lvl_reg;
    logic [15:0]         chunk_reg;
    logic                audio_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [31:0]         now_reg;
    logic                spk_reg;

    // Compaction walk: items visited, depth before the walk, items kept.
    logic [CNT_W-1:0]    k_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    w_reg;

    // Result register.
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [5:0]          dropped_reg;
    logic                evicted_reg;
    logic [15:0]         out_tag_reg;
    logic [7:0]          out_level_reg;
    logic [15:0]         out_chunk_reg;
    logic [5:0]          depth_reg;

    // Cell row.
    pprs_pkg::entry_t    cell_entry [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag   [CAPACITY];
    pprs_pkg::entry_t    ins_entry;
    logic [TAG_BITS-1:0] ins_tag;
    logic                shift;
    logic                ins_en;
    logic [CNT_W-1:0]    ins_pos;

    // Decisions of the current step.
    logic                keep;
    logic                push_lower;
    logic                push_full;
    logic [15:0]         interval;
    logic [31:0]         elapsed;
    logic                due;
    logic                head_hold;
    logic [2:0]          ex_status;
    logic [CNT_W-1:0]    ex_count;
    logic [CNT_W-1:0]    ex_dropped;
    logic                ex_evict;
    logic                ex_dispatch;
    logic                in_accept;
    logic                cfg_write;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && (paddr == 3'd0);

    assign keep       = cell_entry[0].level != lvl_reg;
    assign push_lower = (count_reg != '0) && (lvl_reg < newest_level_reg);
    assign push_full  = count_reg == CNT_W'(CAPACITY);
    assign interval   = (last_chunk_reg > {6'd0, lead_reg})
                        ? last_chunk_reg - {6'd0, lead_reg} : 16'd0;
    assign elapsed    = now_reg - last_time_reg;
    assign due        = (count_reg != '0)
                        && (!once_reg || (interval == 16'd0) || (elapsed >= {16'd0, interval}));
    assign head_hold  = cell_entry[0].audio && spk_reg;

    // Outcome of the command in the execute state.
    always_comb
    begin
        ex_status   = pprs_pkg::ST_NOT_DUE;
        ex_count    = count_reg;
        ex_dropped  = '0;
        ex_evict    = 1'b0;
        ex_dispatch = 1'b0;
        case (op_reg)
            pprs_pkg::OP_PUSH:
            begin
                ex_dropped = n_reg - count_reg;
                if (push_lower)
                begin
                    ex_status = pprs_pkg::ST_REJ_LOWER;
                end
                else if (push_full)
                begin
                    // The new level is at least the tail's, so the head goes.
                    ex_status = pprs_pkg::ST_BUFFERED;
                    ex_evict  = 1'b1;
                end
                else
                begin
                    ex_status = pprs_pkg::ST_BUFFERED;
                    ex_count  = count_reg + 1'b1;
                end
            end
            pprs_pkg::OP_TICK:
            begin
                if (due)
                begin
                    if (head_hold)
                    begin
                        ex_status = pprs_pkg::ST_HELD_AUDIO;
                    end
                    else
                    begin
                        ex_status   = pprs_pkg::ST_DISPATCHED;
                        ex_dispatch = 1'b1;
                        ex_count    = count_reg - 1'b1;
                    end
                end
            end
            pprs_pkg::OP_CLEAR:
            begin
                ex_status  = pprs_pkg::ST_CLEARED;
                ex_dropped = count_reg;
                ex_count   = '0;
            end
            default:
            begin
                ex_status = pprs_pkg::ST_NOT_DUE;
            end
        endcase
    end

    // Cell row control: shift towards the head and load at one position.
    always_comb
    begin
        shift     = 1'b0;
        ins_en    = 1'b0;
        ins_pos   = '0;
        ins_entry = cell_entry[0];
        ins_tag   = cell_tag[0];
        case (state_reg)
            S_COMPACT:
            begin
                // The head leaves; a kept item rejoins behind the earlier kept ones.
                shift   = 1'b1;
                ins_en  = keep;
                ins_pos = n_reg - k_reg - 1'b1 + w_reg;
            end
            S_EXEC:
            begin
                ins_entry.level = lvl_reg;
                ins_entry.chunk = chunk_reg;
                ins_entry.audio = audio_reg;
                ins_tag         = tag_reg;
                if ((op_reg == pprs_pkg::OP_PUSH) && !push_lower)
                begin
                    ins_en = 1'b1;
                    if (push_full)
                    begin
                        shift   = 1'b1;
                        ins_pos = CNT_W'(CAPACITY - 1);
                    end
                    else
                    begin
                        ins_pos = count_reg;
                    end
                end
                else if (ex_dispatch)
                begin
                    shift = 1'b1;
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            pprs_pkg::cell_ctrl_t ctrl;
            pprs_pkg::entry_t     right_entry;
            logic [TAG_BITS-1:0]  right_tag;

            assign ctrl = {shift, ins_en && (ins_pos == CNT_W'(gi))};

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_entry = cell_entry[gi];
                assign right_tag   = cell_tag[gi];
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[gi + 1];
                assign right_tag   = cell_tag[gi + 1];
            end

            pprs_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .right_entry (right_entry),
                .right_tag   (right_tag),
                .ins_entry   (ins_entry),
                .ins_tag     (ins_tag),
                .entry       (cell_entry[gi]),
                .tag         (cell_tag[gi])
            );
        end
    endgenerate

    // Sequencer, bookkeeping and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            newest_level_reg <= '0;
            last_time_reg    <= '0;
            last_chunk_reg   <= '0;
            once_reg         <= 1'b0;
            lead_reg         <= pprs_pkg::LEAD_RESET;
            op_reg           <= pprs_pkg::OP_PUSH;
            lvl_reg          <= '0;
            chunk_reg        <= '0;
            audio_reg        <= 1'b0;
            tag_reg          <= '0;
            now_reg          <= '0;
            spk_reg          <= 1'b0;
            k_reg            <= '0;
            n_reg            <= '0;
            w_reg            <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= pprs_pkg::ST_NOT_DUE;
            dropped_reg      <= '0;
            evicted_reg      <= 1'b0;
            out_tag_reg      <= '0;
            out_level_reg    <= '0;
            out_chunk_reg    <= '0;
            depth_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                lead_reg <= pwdata[9:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg    <= operation;
                        lvl_reg   <= item_level;
                        chunk_reg <= item_chunk_ms;
                        audio_reg <= item_has_audio;
                        tag_reg   <= TAG_BITS'(item_tag);
                        now_reg   <= now_ms;
                        spk_reg   <= speaker_full;
                        k_reg     <= '0;
                        w_reg     <= '0;
                        n_reg     <= count_reg;
                        if ((operation == pprs_pkg::OP_PUSH) && replace_flag
                            && (count_reg != '0))
                        begin
                            state_reg <= S_COMPACT;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_COMPACT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (keep)
                    begin
                        w_reg            <= w_reg + 1'b1;
                        newest_level_reg <= cell_entry[0].level;
                    end
                    if (k_reg == n_reg - 1'b1)
                    begin
                        count_reg <= w_reg + CNT_W'(keep);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    count_reg      <= ex_count;
                    out_valid_reg  <= 1'b1;
                    status_reg     <= ex_status;
                    dropped_reg    <= 6'(ex_dropped);
                    evicted_reg    <= ex_evict;
                    depth_reg      <= 6'(ex_count);
                    out_tag_reg    <= '0;
                    out_level_reg  <= '0;
                    out_chunk_reg  <= '0;
                    if ((op_reg == pprs_pkg::OP_PUSH) && !push_lower)
                    begin
                        newest_level_reg <= lvl_reg;
                    end
                    if (ex_dispatch)
                    begin
                        out_tag_reg    <= 16'(cell_tag[0]);
                        out_level_reg  <= cell_entry[0].level;
                        out_chunk_reg  <= cell_entry[0].chunk;
                        last_time_reg  <= now_reg;
                        last_chunk_reg <= cell_entry[0].chunk;
                        once_reg       <= 1'b1;
                    end
                    if (op_reg == pprs_pkg::OP_CLEAR)
                    begin
                        once_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign dropped_count  = dropped_reg;
    assign evicted_oldest = evicted_reg;
    assign out_tag        = out_tag_reg;
    assign out_level      = out_level_reg;
    assign out_chunk_ms   = out_chunk_reg;
    assign ring_depth     = depth_reg;

    assign prdata = (paddr == 3'd0) ? {22'd0, lead_reg} : 32'd0;
    assign pready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/pprs_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none
`include "playback_priority_ring_scheduler_core_assert.svh"

module pprs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic        evicted_oldest,
    input wire logic [15:0] out_tag,
    input wire logic [7:0]  out_level,
    input wire logic [15:0] out_chunk_ms,
    input wire logic [5:0]  ring_depth,
    input wire logic        pready
);

    // A stalled result transaction keeps its status and depth.
    `PPRS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(status) && $stable(ring_depth), "stalled result changed")

    // After a command is taken, no other is taken in the next cycle.
    `PPRS_ASSERT(a_one_in_flight, clk, rst_n, in_valid && !in_stall |=> in_stall, "second command taken while busy")

    // Item fields are zero unless the result is a dispatch.
    `PPRS_ASSERT(a_fields_zero, clk, rst_n, out_valid && (status != pprs_pkg::ST_DISPATCHED) |-> (out_tag == 16'd0) && (out_level == 8'd0) && (out_chunk_ms == 16'd0), "item fields set without dispatch")

    // An eviction only accompanies a buffered push; a clear leaves nothing.
    `PPRS_ASSERT(a_evict_clear, clk, rst_n, out_valid |-> (!evicted_oldest || (status == pprs_pkg::ST_BUFFERED)) && ((status != pprs_pkg::ST_CLEARED) || (ring_depth == 6'd0)), "eviction or clear result inconsistent")

    // The configuration port never waits.
    `PPRS_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind playback_priority_ring_scheduler_core pprs_checker u_pprs_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the playback priority ring scheduler core.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_MAX = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One queued playback item as the predictor keeps it.
    typedef struct {
        logic [7:0]  level;
        logic [15:0] chunk;
        logic        audio;
        logic [15:0] tag;
    } play_item_t;

    // One result transaction of the block.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  dropped;
        logic        evicted;
        logic [15:0] tag;
        logic [7:0]  level;
        logic [15:0] chunk;
        logic [5:0]  depth;
    } sched_result_t;

    // The scoreboard keeps its own copy of the queue and the dispatch timing,
    // and works out the result of each accepted command in order.
    class ring_scoreboard;
        play_item_t    queue_items[$];
        logic [31:0]   last_time;
        logic [15:0]   last_chunk;
        bit            sent_once;
        logic [9:0]    lead_ms;
        sched_result_t pending_results[$];
        int            fail_count;

        function void reset_state();
            queue_items.delete();
            last_time = '0;
            last_chunk = '0;
            sent_once = 0;
            lead_ms = pprs_pkg::LEAD_RESET;
            pending_results.delete();
            fail_count = 0;
        endfunction

        function int queued_depth();
            return queue_items.size();
        endfunction

        function logic [7:0] newest_level();
            return queue_items[queue_items.size() - 1].level;
        endfunction

        // Notes an accepted command and stores the result it must produce.
        function void note_command(logic [1:0] op, logic [7:0] lvl, logic repl,
                                   logic [15:0] chunk, logic audio, logic [15:0] tag,
                                   logic [31:0] now, logic spk_full);
            sched_result_t r;
            play_item_t    it;
            play_item_t    kept[$];
            logic [31:0]   interval;
            bit            due;
            bit            ok;
            r = '0;
            r.status = pprs_pkg::ST_NOT_DUE;
            if (op == pprs_pkg::OP_PUSH) begin
                ok = 1;
                if (repl) begin
                    foreach (queue_items[i])
                        if (queue_items[i].level == lvl)
                            r.dropped++;
                        else
                            kept.push_back(queue_items[i]);
                    queue_items = kept;
                end
                if (queue_items.size() > 0 && lvl < newest_level()) begin
                    r.status = pprs_pkg::ST_REJ_LOWER;
                    ok = 0;
                end
                // A full ring makes room by evicting its oldest item; the
                // level test above already covers the rejection branch.
                if (ok && queue_items.size() >= DEPTH_MAX) begin
                    void'(queue_items.pop_front());
                    r.evicted = 1'b1;
                end
                if (ok) begin
                    it.level = lvl;
                    it.chunk = chunk;
                    it.audio = audio;
                    it.tag = tag;
                    queue_items.push_back(it);
                    r.status = pprs_pkg::ST_BUFFERED;
                end
            end else if (op == pprs_pkg::OP_TICK) begin
                if (queue_items.size() == 0)
                    due = 0;
                else if (!sent_once)
                    due = 1;
                else begin
                    interval = (last_chunk > lead_ms) ? 32'(last_chunk) - 32'(lead_ms) : '0;
                    due = (interval == 0) || ((now - last_time) >= interval);
                end
                if (due) begin
                    it = queue_items[0];
                    if (it.audio && spk_full)
                        r.status = pprs_pkg::ST_HELD_AUDIO;
                    else begin
                        r.tag = it.tag;
                        r.level = it.level;
                        r.chunk = it.chunk;
                        last_time = now;
                        last_chunk = it.chunk;
                        sent_once = 1;
                        void'(queue_items.pop_front());
                        r.status = pprs_pkg::ST_DISPATCHED;
                    end
                end
            end else if (op == pprs_pkg::OP_CLEAR) begin
                r.dropped = 6'(queue_items.size());
                queue_items.delete();
                sent_once = 0;
                r.status = pprs_pkg::ST_CLEARED;
            end
            r.depth = 6'(queue_items.size());
            pending_results.push_back(r);
        endfunction

        // Compares a result transaction with the oldest stored expectation.
        function void check_result(sched_result_t got);
            sched_result_t exp_r;
            if (pending_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                fail_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                fail_count++;
            end
            if (got.dropped !== exp_r.dropped) begin
                $error("dropped_count: expected %0d, got %0d", exp_r.dropped, got.dropped);
                fail_count++;
            end
            if (got.evicted !== exp_r.evicted) begin
                $error("evicted_oldest: expected %0d, got %0d", exp_r.evicted, got.evicted);
                fail_count++;
            end
            if (got.tag !== exp_r.tag) begin
                $error("out_tag: expected %0h, got %0h", exp_r.tag, got.tag);
                fail_count++;
            end
            if (got.level !== exp_r.level) begin
                $error("out_level: expected %0d, got %0d", exp_r.level, got.level);
                fail_count++;
            end
            if (got.chunk !== exp_r.chunk) begin
                $error("out_chunk_ms: expected %0d, got %0d", exp_r.chunk, got.chunk);
                fail_count++;
            end
            if (got.depth !== exp_r.depth) begin
                $error("ring_depth: expected %0d, got %0d", exp_r.depth, got.depth);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [7:0]  item_level;
    logic        replace_flag;
    logic [15:0] item_chunk_ms;
    logic        item_has_audio;
    logic [15:0] item_tag;
    logic [31:0] now_ms;
    logic        speaker_full;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  dropped_count;
    logic        evicted_oldest;
    logic [15:0] out_tag;
    logic [7:0]  out_level;
    logic [15:0] out_chunk_ms;
    logic [5:0]  ring_depth;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    playback_priority_ring_scheduler_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .item_level(item_level), .replace_flag(replace_flag),
        .item_chunk_ms(item_chunk_ms), .item_has_audio(item_has_audio),
        .item_tag(item_tag), .now_ms(now_ms), .speaker_full(speaker_full),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .dropped_count(dropped_count), .evicted_oldest(evicted_oldest),
        .out_tag(out_tag), .out_level(out_level), .out_chunk_ms(out_chunk_ms),
        .ring_depth(ring_depth),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ring_scoreboard board;

    // Idle percentages for the sender and for the receiver's stall.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned idle_cycles;
    logic [31:0] clock_ms;

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random; each accepted result is sampled at the
    // clock edge and handed to the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                board.check_result({status, dropped_count, evicted_oldest, out_tag,
                                    out_level, out_chunk_ms, ring_depth});
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: counts cycles without any transaction on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one command and holds it until it is accepted. The sender may
    // first idle for a random number of cycles. Valid stays high after the
    // accepting edge; the next command, or the caller, takes it down.
    task automatic send_command(logic [1:0] op, logic [7:0] lvl, logic repl,
                                logic [15:0] chunk, logic audio, logic [15:0] tag,
                                logic [31:0] now, logic spk_full);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        item_level <= lvl;
        replace_flag <= repl;
        item_chunk_ms <= chunk;
        item_has_audio <= audio;
        item_tag <= tag;
        now_ms <= now;
        speaker_full <= spk_full;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_command(op, lvl, repl, chunk, audio, tag, now, spk_full);
    endtask

    task automatic push_item(logic [7:0] lvl, logic repl, logic [15:0] chunk,
                             logic audio, logic [15:0] tag);
        send_command(pprs_pkg::OP_PUSH, lvl, repl, chunk, audio, tag, $urandom,
                     1'($urandom_range(1)));
    endtask

    task automatic tick_at(logic [31:0] now, logic spk_full);
        send_command(pprs_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(1)), 16'($urandom),
                     1'($urandom_range(1)), 16'($urandom), now, spk_full);
    endtask

    // Waits until every expected result has arrived, then lets the block settle
    // for longer than a replacing push can take.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH_MAX + 8) @(posedge clk);
    endtask

    // APB write of the dispatch lead register: setup cycle, then access cycle.
    task automatic write_lead(logic [9:0] lead);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {22'd0, lead};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.lead_ms = lead;
    endtask

    // A random command; mostly pushes at rising levels and ticks, with the
    // odd clear so the queue both fills up and drains.
    task automatic random_command();
        int unsigned pick;
        logic [7:0]  lvl;
        pick = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(120);
        if (pick < 50) begin
            // Levels mostly near the tail so that replacement and eviction happen.
            if (board.queued_depth() > 0 && $urandom_range(9) < 8)
                lvl = board.newest_level() + 8'($urandom_range(2));
            else
                lvl = 8'($urandom);
            if ($urandom_range(9) == 0)
                lvl = lvl - 8'($urandom_range(1, 3));
            push_item(lvl, ($urandom_range(4) == 0),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200)),
                      1'($urandom_range(1)), 16'($urandom));
        end else if (pick < 96) begin
            if ($urandom_range(19) == 0)
                clock_ms = $urandom;
            tick_at(clock_ms, ($urandom_range(3) == 0));
        end else if (pick < 99) begin
            send_command(pprs_pkg::OP_CLEAR, 8'($urandom), 1'($urandom_range(1)),
                         16'($urandom), 1'($urandom_range(1)), 16'($urandom), $urandom,
                         1'($urandom_range(1)));
        end else begin
            // The unused operation code answers with the not-due status and the current depth only.
            send_command(OP_UNUSED, 8'($urandom), 1'($urandom_range(1)),
                         16'($urandom), 1'($urandom_range(1)), 16'($urandom), $urandom,
                         1'($urandom_range(1)));
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operation = pprs_pkg::OP_PUSH;
        item_level = '0;
        replace_flag = 1'b0;
        item_chunk_ms = '0;
        item_has_audio = 1'b0;
        item_tag = '0;
        now_ms = '0;
        speaker_full = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        clock_ms = '0;
        sender_idle_pct = 8;
        receiver_stall_pct = 59;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset lead. A tick on an empty queue is not due,
        // and the first dispatch after reset goes at once.
        tick_at(32'd0, 1'b0);
        push_item(8'd0, 1'b0, 16'd0, 1'b0, 16'h0000);
        push_item(8'd255, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF);
        push_item(8'd10, 1'b0, 16'd5, 1'b0, 16'h1234);
        // Lower level after replace: nothing equal queued, push still rejected.
        push_item(8'd10, 1'b1, 16'd5, 1'b0, 16'h5555);
        tick_at(32'd0, 1'b0);
        // The next head carries audio and is held while the speaker is full.
        tick_at(32'hFFFF_FFF0, 1'b1);
        tick_at(32'hFFFF_FFF0, 1'b0);
        // Long interval: the last chunk far exceeds the lead, so these ticks are not due.
        push_item(8'd255, 1'b0, 16'd100, 1'b0, 16'hA5A5);
        push_item(8'd255, 1'b0, 16'd40, 1'b0, 16'h5A5A);
        tick_at(32'd1000, 1'b0);
        tick_at(32'd1084, 1'b0);
        tick_at(32'd1085, 1'b0);
        // Replacement removes all four equal items, then a clear, and a clear with an empty queue.
        push_item(8'd255, 1'b0, 16'd1, 1'b1, 16'h0001);
        push_item(8'd255, 1'b0, 16'd2, 1'b0, 16'h0002);
        push_item(8'd255, 1'b1, 16'd3, 1'b0, 16'h0003);
        send_command(pprs_pkg::OP_CLEAR, 8'd0, 1'b0, 16'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_command(pprs_pkg::OP_CLEAR, 8'd0, 1'b0, 16'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_command(OP_UNUSED, 8'd7, 1'b1, 16'd7, 1'b1, 16'd7, 32'd7, 1'b1);
        drain_results();

        // Fill the ring past capacity to force evictions, then a lower push
        // against a full ring, and a wrapping time difference.
        write_lead(10'd0);
        for (int i = 0; i < DEPTH_MAX + 3; i++)
            push_item(8'd50, 1'b0, 16'd60, 1'b0, 16'(i));
        push_item(8'd49, 1'b0, 16'd1, 1'b0, 16'hBEEF);
        tick_at(32'hFFFF_FFFF, 1'b0);
        tick_at(32'd58, 1'b0);
        tick_at(32'd59, 1'b0);
        push_item(8'd50, 1'b1, 16'd1, 1'b0, 16'h0F0F);
        drain_results();

        // Random part in three idling phases over several lead settings.
        write_lead(10'd1023);
        clock_ms = '0;
        for (int i = 0; i < 130; i++)
            random_command();
        drain_results();
        sender_idle_pct = 59;
        receiver_stall_pct = 8;
        write_lead(10'($urandom_range(1, 60)));
        for (int i = 0; i < 130; i++)
            random_command();
        drain_results();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_lead(pprs_pkg::LEAD_RESET);
        for (int i = 0; i < 130; i++)
            random_command();
        drain_results();

        if (board.fail_count == 0 && board.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
